>>> rtl/core/monthly_min_max_mean_stats_defines.svh
// Assertion macros shared by the monthly statistics RTL.
// Uses the clk and rst names of the module that expands them.
`ifndef MONTHLY_MIN_MAX_MEAN_STATS_DEFINES_SVH
`define MONTHLY_MIN_MAX_MEAN_STATS_DEFINES_SVH
`ifndef SYNTH
`define MMMS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("monthly stats assertion failed");
`define MMMS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("monthly stats assertion failed");
`else
`define MMMS_ASSERT(lbl, prop)
`define MMMS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/core/mmms_pkg.sv
// Package for the monthly statistics block: widths, constants, bin entry
// layout and the structs passed between the controller, bin store and divider.
`default_nettype none

package mmms_pkg;

  localparam int NUM_BINS    = 12;
  localparam int COUNT_BITS  = 16;
  localparam int BIN_W       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  localparam int MONTH_W     = 4;
  localparam int TEMP_W      = 12;
  localparam int SUM_W       = 32;
  localparam int LOW_W       = 15;
  localparam int OUT_COUNT_W = 16;

  // divider operands: numerator 2*|sum| + count, denominator 2*count
  localparam int NUM_W       = SUM_W + 2;
  localparam int DEN_W       = COUNT_BITS + 1;
  localparam int DIV_CNT_W   = $clog2(NUM_W + 1);

  // three averages per month: low, mean, high
  localparam int NUM_AVG     = 3;
  localparam int AVG_IDX_W   = 2;
  localparam logic [AVG_IDX_W-1:0] AVG_LOW  = 2'd0;
  localparam logic [AVG_IDX_W-1:0] AVG_MEAN = 2'd1;
  localparam logic [AVG_IDX_W-1:0] AVG_HIGH = 2'd2;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic signed [LOW_W-1:0] NO_LOW_MARK = LOW_W'(9990);

  typedef struct packed {
    logic [COUNT_BITS-1:0]    count;
    logic signed [SUM_W-1:0]  sum_low;
    logic signed [SUM_W-1:0]  sum_mean;
    logic signed [SUM_W-1:0]  sum_high;
    logic signed [LOW_W-1:0]  min_low;
    logic signed [TEMP_W-1:0] max_high;
  } bin_entry_t;

  localparam int ENTRY_W = $bits(bin_entry_t);

  localparam bin_entry_t ENTRY_RESET = '{
    count:    '0,
    sum_low:  '0,
    sum_mean: '0,
    sum_high: '0,
    min_low:  NO_LOW_MARK,
    max_high: '0
  };

  typedef struct packed {
    logic             rd_en;
    logic [BIN_W-1:0] rd_addr;
    logic             wr_en;
    logic [BIN_W-1:0] wr_addr;
    bin_entry_t       wr_data;
  } store_cmd_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/mmms_rec_if.sv
// Input channel of the monthly statistics block: record or report beats.
// Depends on mmms_pkg for field widths.
`default_nettype none

interface mmms_rec_if;
  import mmms_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [MONTH_W-1:0]       month;
  logic signed [TEMP_W-1:0] low_temp;
  logic signed [TEMP_W-1:0] mean_temp;
  logic signed [TEMP_W-1:0] high_temp;

  modport source (
    output valid, opcode, month, low_temp, mean_temp, high_temp,
    input  ready
  );

  modport sink (
    input  valid, opcode, month, low_temp, mean_temp, high_temp,
    output ready
  );

endinterface

`default_nettype wire

>>> rtl/core/mmms_res_if.sv
// Output channel of the monthly statistics block: one beat per month line.
// Depends on mmms_pkg for field widths.
`default_nettype none

interface mmms_res_if;
  import mmms_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MONTH_W-1:0]       month_number;
  logic [OUT_COUNT_W-1:0]   record_count;
  logic signed [TEMP_W-1:0] avg_low;
  logic signed [LOW_W-1:0]  lowest_low;
  logic signed [TEMP_W-1:0] avg_mean;
  logic signed [TEMP_W-1:0] avg_high;
  logic signed [TEMP_W-1:0] highest_high;
  logic                     empty_month;
  logic                     last_line;

  modport source (
    output valid, month_number, record_count, avg_low, lowest_low, avg_mean,
           avg_high, highest_high, empty_month, last_line,
    input  ready
  );

  modport sink (
    input  valid, month_number, record_count, avg_low, lowest_low, avg_mean,
           avg_high, highest_high, empty_month, last_line,
    output ready
  );

endinterface

`default_nettype wire

>>> rtl/core/mmms_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
`default_nettype none

module mmms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mmms_bin_store.sv
// Bin store: the per-month statistics memory plus one valid bit per bin.
// Depends on mmms_pkg and mmms_ram; unwritten bins read as their reset value.
`default_nettype none

module mmms_bin_store (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mmms_pkg::store_cmd_t cmd,
  output mmms_pkg::bin_entry_t      rd_entry
);
  import mmms_pkg::*;

  logic [NUM_BINS-1:0] valid_bits;
  logic                rd_valid;
  logic [ENTRY_W-1:0]  ram_rdata;

  mmms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cmd.wr_addr),
    .wdata (cmd.wr_data),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        valid_bits[cmd.wr_addr] <= 1'b1;
      end
      // sample the valid bit alongside the RAM read so both line up
      if (cmd.rd_en) begin
        rd_valid <= valid_bits[cmd.rd_addr];
      end
    end
  end

  assign rd_entry = rd_valid ? bin_entry_t'(ram_rdata) : ENTRY_RESET;

endmodule

`default_nettype wire

>>> rtl/core/mmms_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on mmms_pkg for operand widths and request/response structs.
`default_nettype none

module mmms_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mmms_pkg::div_req_t req,
  output mmms_pkg::div_rsp_t      rsp
);
  import mmms_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W-1:0]     den;
  logic [DEN_W-1:0]     rem;
  logic [NUM_W-1:0]     quo;

  logic [DEN_W:0]       rem_sh;
  logic                 take;
  logic [DEN_W-1:0]     rem_next;

  always_comb begin
    rem_sh   = {rem, quo[NUM_W-1]};
    take     = (rem_sh >= {1'b0, den});
    rem_next = take ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= DIV_CNT_W'(NUM_W);
      den <= req.den;
      rem <= '0;
      quo <= req.num;
    end else if (busy) begin
      // shift the numerator out as quotient bits shift in
      cnt <= cnt - DIV_CNT_W'(1);
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], take};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

`default_nettype wire

>>> rtl/core/monthly_min_max_mean_stats.sv
// Top level of the monthly statistics block: controller and output register.
// Depends on mmms_pkg, mmms_rec_if, mmms_res_if, mmms_bin_store and mmms_div.
// A record beat (opcode 0) reads its month's entry from the bin memory in
// S_IDLE and writes back the updated entry in S_UPDATE; records with a
// month outside 1..12 are dropped with no bin access. A report beat (opcode 1)
// walks the twelve bins in order; each non-empty month needs a bin read plus
// three roundings through the shared serial divider, and the walk stalls
// while the output side holds off. An empty month skips the divider. Bins
// come out of reset cleared through per-bin valid bits, with no clearing pass.
`default_nettype none
`include "monthly_min_max_mean_stats_defines.svh"

module monthly_min_max_mean_stats (
  input wire logic clk,
  input wire logic rst,
  mmms_rec_if.sink   rec,
  mmms_res_if.source res
);
  import mmms_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_UPDATE    = 7'b0000010,
    S_RPT_READ  = 7'b0000100,
    S_RPT_LOAD  = 7'b0001000,
    S_DIV_ISSUE = 7'b0010000,
    S_DIVIDE    = 7'b0100000,
    S_EMIT      = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  store_cmd_t store_cmd;
  bin_entry_t rd_entry;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  // captured record beat
  logic [BIN_W-1:0]         rec_bin;
  logic signed [TEMP_W-1:0] rec_low;
  logic signed [TEMP_W-1:0] rec_mean;
  logic signed [TEMP_W-1:0] rec_high;

  // report walk
  logic [BIN_W-1:0]         bin;
  logic [AVG_IDX_W-1:0]     fld;
  logic [COUNT_BITS-1:0]    cur_count;
  logic signed [SUM_W-1:0]  cur_sum [NUM_AVG];
  logic signed [LOW_W-1:0]  cur_min;
  logic signed [TEMP_W-1:0] cur_max;
  logic signed [TEMP_W-1:0] avg [NUM_AVG];
  logic                     neg;

  // output register
  logic                     out_valid;
  logic [MONTH_W-1:0]       out_month;
  logic [OUT_COUNT_W-1:0]   out_count;
  logic signed [TEMP_W-1:0] out_avg_low;
  logic signed [LOW_W-1:0]  out_lowest;
  logic signed [TEMP_W-1:0] out_avg_mean;
  logic signed [TEMP_W-1:0] out_avg_high;
  logic signed [TEMP_W-1:0] out_highest;
  logic                     out_empty;
  logic                     out_last;

  logic                     rec_fire;
  logic                     month_ok;
  logic [MONTH_W-1:0]       month_m1;
  logic                     out_free;
  logic                     cnt_sat;
  logic signed [SUM_W-1:0]  sel_sum;
  logic                     sel_neg;
  logic [SUM_W:0]           sel_ext;
  logic [SUM_W:0]           sel_mag;
  logic [TEMP_W-1:0]        quot_lo;
  logic                     last_bin;
  logic                     last_fld;

  assign rec.ready = (state == S_IDLE) && !rst;
  assign rec_fire  = rec.valid && rec.ready;
  assign month_ok  = (rec.month != '0) && (32'(rec.month) <= NUM_BINS);
  assign month_m1  = rec.month - MONTH_W'(1);
  assign out_free  = !out_valid || res.ready;
  assign last_bin  = (bin == BIN_W'(NUM_BINS - 1));
  assign last_fld  = (fld == AVG_HIGH);
  assign cnt_sat   = (rd_entry.count == COUNT_MAX);
  assign quot_lo   = div_rsp.quot[TEMP_W-1:0];

  mmms_bin_store u_store (
    .clk      (clk),
    .rst      (rst),
    .cmd      (store_cmd),
    .rd_entry (rd_entry)
  );

  mmms_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // bin memory access: read on accept or during the report walk, write on update
  always_comb begin
    store_cmd = '0;
    case (state)
      S_IDLE: begin
        store_cmd.rd_en   = rec_fire && (rec.opcode == OP_RECORD) && month_ok;
        store_cmd.rd_addr = BIN_W'(month_m1);
      end
      S_UPDATE: begin
        store_cmd.wr_en            = 1'b1;
        store_cmd.wr_addr          = rec_bin;
        store_cmd.wr_data          = rd_entry;
        if (!cnt_sat) begin
          store_cmd.wr_data.count    = rd_entry.count + COUNT_BITS'(1);
          store_cmd.wr_data.sum_low  = rd_entry.sum_low + SUM_W'(rec_low);
          store_cmd.wr_data.sum_mean = rd_entry.sum_mean + SUM_W'(rec_mean);
          store_cmd.wr_data.sum_high = rd_entry.sum_high + SUM_W'(rec_high);
        end
        if (LOW_W'(rec_low) < rd_entry.min_low) begin
          store_cmd.wr_data.min_low = LOW_W'(rec_low);
        end
        if (rec_high > rd_entry.max_high) begin
          store_cmd.wr_data.max_high = rec_high;
        end
      end
      S_RPT_READ: begin
        store_cmd.rd_en   = 1'b1;
        store_cmd.rd_addr = bin;
      end
      default: begin
        store_cmd = '0;
      end
    endcase
  end

  // rounding operands: (2*|sum| + n) / (2*n)
  always_comb begin
    sel_sum         = cur_sum[fld];
    sel_neg         = sel_sum[SUM_W-1];
    sel_ext         = {sel_sum[SUM_W-1], sel_sum};
    sel_mag         = sel_neg ? -sel_ext : sel_ext;
    div_req.start   = (state == S_DIV_ISSUE);
    div_req.num     = {sel_mag, 1'b0} + NUM_W'(cur_count);
    div_req.den     = {cur_count, 1'b0};
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (rec_fire) begin
          if (rec.opcode == OP_REPORT) begin
            state_next = S_RPT_READ;
          end else if (month_ok) begin
            state_next = S_UPDATE;
          end
        end
      end
      S_UPDATE:    state_next = S_IDLE;
      S_RPT_READ:  state_next = S_RPT_LOAD;
      S_RPT_LOAD: begin
        state_next = (rd_entry.count == '0) ? S_EMIT : S_DIV_ISSUE;
      end
      S_DIV_ISSUE: state_next = S_DIVIDE;
      S_DIVIDE: begin
        if (div_rsp.done) begin
          state_next = last_fld ? S_EMIT : S_DIV_ISSUE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = last_bin ? S_IDLE : S_RPT_READ;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (rec_fire) begin
          rec_bin  <= BIN_W'(month_m1);
          rec_low  <= rec.low_temp;
          rec_mean <= rec.mean_temp;
          rec_high <= rec.high_temp;
          bin      <= '0;
        end
      end
      S_RPT_LOAD: begin
        cur_count         <= rd_entry.count;
        cur_sum[AVG_LOW]  <= rd_entry.sum_low;
        cur_sum[AVG_MEAN] <= rd_entry.sum_mean;
        cur_sum[AVG_HIGH] <= rd_entry.sum_high;
        cur_min           <= rd_entry.min_low;
        cur_max           <= rd_entry.max_high;
        fld               <= AVG_LOW;
        if (rd_entry.count == '0) begin
          avg[AVG_LOW]  <= '0;
          avg[AVG_MEAN] <= '0;
          avg[AVG_HIGH] <= '0;
        end
      end
      S_DIV_ISSUE: begin
        neg <= sel_neg;
      end
      S_DIVIDE: begin
        if (div_rsp.done) begin
          avg[fld] <= neg ? -quot_lo : quot_lo;
          fld      <= fld + AVG_IDX_W'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_month    <= MONTH_W'(bin) + MONTH_W'(1);
          out_count    <= OUT_COUNT_W'(cur_count);
          out_avg_low  <= avg[AVG_LOW];
          out_lowest   <= cur_min;
          out_avg_mean <= avg[AVG_MEAN];
          out_avg_high <= avg[AVG_HIGH];
          out_highest  <= cur_max;
          out_empty    <= (cur_count == '0);
          out_last     <= last_bin;
          bin          <= bin + BIN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign res.valid        = out_valid;
  assign res.month_number = out_month;
  assign res.record_count = out_count;
  assign res.avg_low      = out_avg_low;
  assign res.lowest_low   = out_lowest;
  assign res.avg_mean     = out_avg_mean;
  assign res.avg_high     = out_avg_high;
  assign res.highest_high = out_highest;
  assign res.empty_month  = out_empty;
  assign res.last_line    = out_last;

  `MMMS_ASSERT(a_no_rd_wr_overlap, store_cmd.wr_en |-> !store_cmd.rd_en)
  `MMMS_ASSERT(a_count_step, (state == S_UPDATE) |->
    ((store_cmd.wr_data.count == rd_entry.count + COUNT_BITS'(1)) ||
     (cnt_sat && store_cmd.wr_data.count == COUNT_MAX)))
  `MMMS_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy)
  `MMMS_ASSERT(a_empty_zero, (res.valid && res.empty_month) |->
    (res.record_count == '0 && res.avg_low == '0 && res.avg_mean == '0 &&
     res.avg_high == '0))
  `MMMS_ASSERT(a_last_month, (res.valid && res.last_line) |->
    (res.month_number == MONTH_W'(NUM_BINS)))

endmodule

`default_nettype wire
